[rtl/qclt_pkg.sv]
// Package for the quoted column line tokenizer.
// Holds result kinds, character codes and the per-item result batch type.
// No dependencies.
package qclt_pkg;

    localparam int MAX_RESULTS = 4;
    localparam int CNT_W       = 3;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_ESCAPE = 8'h5C;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef enum logic [1:0] {
        KIND_BYTE      = 2'd0,
        KIND_COL_END   = 2'd1,
        KIND_REC_END   = 2'd2,
        KIND_QUOTE_ERR = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
    } entry_t;

    typedef struct packed {
        logic [CNT_W-1:0]            count;
        entry_t [MAX_RESULTS-1:0]    ent;
    } batch_t;

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

endpackage

[rtl/qclt_scan.sv]
// Scanner for the quoted column line tokenizer: line state registers and the
// single-pass decode of one byte or line end into a batch of up to four results.
// Depends on qclt_pkg.
module qclt_scan (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic [7:0]            text_byte,
    input  logic                  line_end,
    output qclt_pkg::batch_t      batch
);

    typedef enum logic [1:0] {
        MODE_GAP    = 2'd0,
        MODE_PLAIN  = 2'd1,
        MODE_QUOTED = 2'd2,
        MODE_SKIP   = 2'd3
    } mode_t;

    mode_t mode_reg, mode_next, fin_mode;
    logic  esc_reg, esc_next;
    logic  semi_reg, semi_next;
    logic  colb_reg, colb_next;
    logic  linec_reg, linec_next;

    logic [qclt_pkg::CNT_W-1:0] n;
    logic fin, comment, plain, skip_rest;

    always_comb begin
        mode_next  = mode_reg;
        esc_next   = esc_reg;
        semi_next  = semi_reg;
        colb_next  = colb_reg;
        linec_next = linec_reg;
        fin        = 1'b0;
        fin_mode   = MODE_GAP;
        comment    = 1'b0;
        plain      = 1'b0;
        skip_rest  = 1'b0;
        n          = '0;
        batch      = '0;

        if (line_end) begin
            if (mode_reg == MODE_SKIP) begin
                mode_next  = MODE_GAP;
                esc_next   = 1'b0;
                semi_next  = 1'b0;
                colb_next  = 1'b0;
                linec_next = 1'b0;
            end else begin
                fin      = 1'b1;
                fin_mode = MODE_GAP;
            end
        end else if (mode_reg == MODE_SKIP) begin
            mode_next = MODE_SKIP;
        end else if (text_byte == qclt_pkg::CH_NUL) begin
            fin      = 1'b1;
            fin_mode = MODE_SKIP;
        end else begin
            if (mode_reg == MODE_GAP) begin
                if (qclt_pkg::is_space(text_byte)) begin
                    mode_next = MODE_GAP;
                end else if (text_byte == qclt_pkg::CH_QUOTE) begin
                    mode_next = MODE_QUOTED;
                    colb_next = 1'b0;
                end else begin
                    mode_next = MODE_PLAIN;
                    colb_next = 1'b0;
                    plain     = 1'b1;
                end
            end else if (mode_reg == MODE_PLAIN) begin
                plain = 1'b1;
            end else begin
                if (esc_reg) begin
                    batch.ent[n[1:0]] = '{kind: qclt_pkg::KIND_BYTE, data: text_byte};
                    n = n + 1'b1;
                    colb_next = 1'b1;
                    esc_next  = 1'b0;
                end else if (text_byte == qclt_pkg::CH_QUOTE) begin
                    batch.ent[n[1:0]] = '{kind: qclt_pkg::KIND_COL_END, data: 8'h00};
                    n = n + 1'b1;
                    linec_next = 1'b1;
                    mode_next  = MODE_GAP;
                    colb_next  = 1'b0;
                end else if (text_byte == qclt_pkg::CH_ESCAPE) begin
                    esc_next = 1'b1;
                end else begin
                    batch.ent[n[1:0]] = '{kind: qclt_pkg::KIND_BYTE, data: text_byte};
                    n = n + 1'b1;
                    colb_next = 1'b1;
                end
            end

            if (plain) begin
                if (semi_reg) begin
                    semi_next = 1'b0;
                    if (text_byte == qclt_pkg::CH_SEMI) begin
                        comment   = 1'b1;
                        skip_rest = 1'b1;
                    end else begin
                        batch.ent[n[1:0]] = '{kind: qclt_pkg::KIND_BYTE,
                                              data: qclt_pkg::CH_SEMI};
                        n = n + 1'b1;
                        colb_next = 1'b1;
                    end
                end
                if (!skip_rest) begin
                    if (esc_reg) begin
                        batch.ent[n[1:0]] = '{kind: qclt_pkg::KIND_BYTE, data: text_byte};
                        n = n + 1'b1;
                        colb_next = 1'b1;
                        esc_next  = 1'b0;
                    end else if (qclt_pkg::is_space(text_byte)) begin
                        batch.ent[n[1:0]] = '{kind: qclt_pkg::KIND_COL_END, data: 8'h00};
                        n = n + 1'b1;
                        linec_next = 1'b1;
                        mode_next  = MODE_GAP;
                        colb_next  = 1'b0;
                    end else if (text_byte == qclt_pkg::CH_ESCAPE) begin
                        esc_next = 1'b1;
                    end else if (text_byte == qclt_pkg::CH_HASH) begin
                        comment = 1'b1;
                    end else if (text_byte == qclt_pkg::CH_SEMI) begin
                        semi_next = 1'b1;
                    end else begin
                        batch.ent[n[1:0]] = '{kind: qclt_pkg::KIND_BYTE, data: text_byte};
                        n = n + 1'b1;
                        colb_next = 1'b1;
                    end
                end
            end
        end

        if (fin) begin
            if (mode_reg == MODE_QUOTED) begin
                if (esc_reg) begin
                    batch.ent[n[1:0]] = '{kind: qclt_pkg::KIND_BYTE,
                                          data: qclt_pkg::CH_ESCAPE};
                    n = n + 1'b1;
                end
                batch.ent[n[1:0]] = '{kind: qclt_pkg::KIND_QUOTE_ERR, data: 8'h00};
                n = n + 1'b1;
            end else begin
                if (mode_reg == MODE_PLAIN) begin
                    if (semi_reg) begin
                        batch.ent[n[1:0]] = '{kind: qclt_pkg::KIND_BYTE,
                                              data: qclt_pkg::CH_SEMI};
                        n = n + 1'b1;
                    end
                    if (esc_reg) begin
                        batch.ent[n[1:0]] = '{kind: qclt_pkg::KIND_BYTE,
                                              data: qclt_pkg::CH_ESCAPE};
                        n = n + 1'b1;
                    end
                    batch.ent[n[1:0]] = '{kind: qclt_pkg::KIND_COL_END, data: 8'h00};
                    n = n + 1'b1;
                end
                if (linec_reg || (mode_reg == MODE_PLAIN)) begin
                    batch.ent[n[1:0]] = '{kind: qclt_pkg::KIND_REC_END, data: 8'h00};
                    n = n + 1'b1;
                end
            end
            mode_next  = fin_mode;
            esc_next   = 1'b0;
            semi_next  = 1'b0;
            colb_next  = 1'b0;
            linec_next = 1'b0;
        end

        if (comment) begin
            if (colb_next) begin
                batch.ent[n[1:0]] = '{kind: qclt_pkg::KIND_COL_END, data: 8'h00};
                n = n + 1'b1;
                linec_next = 1'b1;
            end
            if (linec_next) begin
                batch.ent[n[1:0]] = '{kind: qclt_pkg::KIND_REC_END, data: 8'h00};
                n = n + 1'b1;
            end
            mode_next  = MODE_SKIP;
            esc_next   = 1'b0;
            semi_next  = 1'b0;
            colb_next  = 1'b0;
            linec_next = 1'b0;
        end

        batch.count = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_GAP;
            esc_reg   <= 1'b0;
            semi_reg  <= 1'b0;
            colb_reg  <= 1'b0;
            linec_reg <= 1'b0;
        end else if (accept) begin
            mode_reg  <= mode_next;
            esc_reg   <= esc_next;
            semi_reg  <= semi_next;
            colb_reg  <= colb_next;
            linec_reg <= linec_next;
        end
    end

endmodule

[rtl/qclt_emit.sv]
// Result register for the quoted column line tokenizer: holds one batch of
// up to four results and shifts them out one transfer per cycle while m_ready is high.
// Depends on qclt_pkg.
module qclt_emit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  qclt_pkg::batch_t      batch,
    output logic                  can_load,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_kind,
    output logic [7:0]            m_out_byte,
    output logic                  m_last
);

    logic [qclt_pkg::CNT_W-1:0]                cnt_reg, cnt_next;
    qclt_pkg::entry_t [qclt_pkg::MAX_RESULTS-1:0] ent_reg, ent_next;
    logic pop;

    assign m_valid    = (cnt_reg != '0);
    assign pop        = m_valid && m_ready;
    assign can_load   = (cnt_reg == '0) || ((cnt_reg == qclt_pkg::CNT_W'(1)) && m_ready);
    assign m_kind     = ent_reg[0].kind;
    assign m_out_byte = ent_reg[0].data;
    assign m_last     = (cnt_reg == qclt_pkg::CNT_W'(1));

    always_comb begin
        cnt_next = cnt_reg;
        ent_next = ent_reg;
        if (load) begin
            cnt_next = batch.count;
            ent_next = batch.ent;
        end else if (pop) begin
            cnt_next = cnt_reg - 1'b1;
            for (int i = 0; i < qclt_pkg::MAX_RESULTS - 1; i++) begin
                ent_next[i] = ent_reg[i+1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
    end

endmodule

[rtl/quoted_column_line_tokenizer_core.sv]
// Quoted column line tokenizer, top level.
// Input channel s_*: one text byte or a line end (s_line_end) per transfer.
// Result channel m_*: column bytes, column ends, record ends and a
// missing-quote error, with m_last on the final result of each input item.
// Each accepted item is decoded in the cycle it is taken and its zero to
// four results land in the result register; the first result is valid in the
// cycle after the transfer. An item that gives k results occupies the
// result register until all k have gone out; the next item is taken in the
// cycle the last of them goes out, so while m_ready stays high items with
// at most one result flow at one per cycle. Items with no result are taken
// whenever the register is empty or draining its last entry.
// A stall on m_ready holds the current result and blocks new input while
// any result is pending, including a single final one.
// Reset (aresetn low, synchronous) empties the result register and returns
// the scanner to the between-columns state with all line flags clear.
// Depends on qclt_pkg, qclt_scan, qclt_emit.
module quoted_column_line_tokenizer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_text_byte,
    input  logic        s_line_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_out_byte,
    output logic        m_last
);

    qclt_pkg::batch_t batch;
    logic             accept;

    assign accept = s_valid && s_ready;

    qclt_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .text_byte (s_text_byte),
        .line_end  (s_line_end),
        .batch     (batch)
    );

    qclt_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (accept),
        .batch      (batch),
        .can_load   (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_kind     (m_kind),
        .m_out_byte (m_out_byte),
        .m_last     (m_last)
    );

`ifndef SYNTH
    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while result register empty");

    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_kind == qclt_pkg::KIND_QUOTE_ERR)) |-> m_last)
        else $error("quote error not final result of its item");

    a_rec_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_kind == qclt_pkg::KIND_REC_END)) |-> m_last)
        else $error("record end not final result of its item");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last && !accept) |=> !m_valid)
        else $error("result appeared without an accepted item");
`endif

endmodule
